// ----- src/alc_pkg.sv -----
package alc_pkg;

  // raw count width and scaled count width (16 bits times at most 2^9 after scaling)
  localparam int CNT_W = 16;
  localparam int CH_W = 25;
  localparam int LUX_W = 16;
  localparam int GAIN_SHIFT = 4;

  // segment tables: breakpoints at 9 fraction bits, coefficients at 14
  localparam int SEGMENTS = 8;
  localparam int SEG_W = 3;
  localparam int TAB_W = 10;
  localparam int TAB_RATIO_BITS = 9;
  localparam int TAB_COEF_BITS = 14;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_GAIN = 2'd0;
  localparam logic [1:0] REG_TIME = 2'd1;
  localparam logic [1:0] REG_PKG = 2'd2;

  localparam logic [1:0] TIME_13MS = 2'd0;
  localparam logic [1:0] TIME_101MS = 2'd1;
  localparam logic [1:0] TIME_402MS = 2'd2;

  typedef logic [TAB_W-1:0] tab_t;

  localparam tab_t SEG_BRK [0:1][0:SEGMENTS-1] = '{
    '{10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a, 10'h29a},
    '{10'h043, 10'h085, 10'h0c8, 10'h10a, 10'h14d, 10'h19a, 10'h29a, 10'h29a}
  };

  localparam tab_t SEG_OFF [0:1][0:SEGMENTS-1] = '{
    '{10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000},
    '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037, 10'h000}
  };

  localparam tab_t SEG_SLOPE [0:1][0:SEGMENTS-1] = '{
    '{10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000},
    '{10'h1ad, 10'h2c1, 10'h363, 10'h3df, 10'h1dd, 10'h127, 10'h02b, 10'h000}
  };

  typedef struct packed {
    logic       gain_high;
    logic [1:0] integration_time_sel;
    logic       package_kind;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ----- src/alc_cfg.sv -----
module alc_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [alc_pkg::ADDR_W-1:0] paddr,
  input  logic [alc_pkg::DATA_W-1:0] pwdata,
  output logic [alc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output alc_pkg::cfg_t              cfg
);

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[alc_pkg::ADDR_W-1:2];
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_high <= 1'b0;
      cfg.integration_time_sel <= alc_pkg::TIME_402MS;
      cfg.package_kind <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        alc_pkg::REG_GAIN: cfg.gain_high <= pwdata[0];
        alc_pkg::REG_TIME: cfg.integration_time_sel <= pwdata[1:0];
        alc_pkg::REG_PKG:  cfg.package_kind <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      alc_pkg::REG_GAIN: prdata = alc_pkg::DATA_W'(cfg.gain_high);
      alc_pkg::REG_TIME: prdata = alc_pkg::DATA_W'(cfg.integration_time_sel);
      alc_pkg::REG_PKG:  prdata = alc_pkg::DATA_W'(cfg.package_kind);
      default:           prdata = '0;
    endcase
  end

endmodule

// ----- src/alc_front.sv -----
module alc_front #(
  parameter int CHAN_SCALE_BITS = 10,
  parameter int RATIO_SCALE_BITS = 9
) (
  input  logic                    clk,
  input  logic                    rst,
  input  alc_pkg::cfg_t           cfg,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [31:0]             s_tdata,
  input  logic                    fifo_full,
  output logic                    push,
  output logic [3*alc_pkg::CH_W+RATIO_SCALE_BITS:0] push_data
);

  localparam int NW = alc_pkg::CH_W + 1 + RATIO_SCALE_BITS;
  localparam int SW = CHAN_SCALE_BITS + 9;
  localparam int PW = alc_pkg::CNT_W + SW;
  localparam int unsigned S13 = ((322 << CHAN_SCALE_BITS) * 2 + 11) / 22;
  localparam int unsigned S101 = ((322 << CHAN_SCALE_BITS) * 2 + 81) / 162;

  logic [SW-1:0] scale_base;
  logic [SW-1:0] scale;
  logic [PW-1:0] prod0;
  logic [PW-1:0] prod1;
  logic          adv;

  // stage 0 holds scaled counts, stages 1..NW each resolve one quotient bit
  logic                     st_vld [0:NW];
  logic [alc_pkg::CH_W-1:0] st_c0 [0:NW];
  logic [alc_pkg::CH_W-1:0] st_c1 [0:NW];
  logic [alc_pkg::CH_W-1:0] st_rem [0:NW];
  logic [NW-1:0]            st_quo [0:NW];

  always_comb begin
    unique case (cfg.integration_time_sel)
      alc_pkg::TIME_13MS:  scale_base = SW'(S13);
      alc_pkg::TIME_101MS: scale_base = SW'(S101);
      default:             scale_base = SW'(1) << CHAN_SCALE_BITS;
    endcase
    scale = cfg.gain_high ? scale_base : (scale_base << alc_pkg::GAIN_SHIFT);
  end

  assign prod0 = PW'(s_tdata[15:0]) * PW'(scale);
  assign prod1 = PW'(s_tdata[31:16]) * PW'(scale);

  assign adv = ~st_vld[NW] | ~fifo_full;
  // nothing is taken while reset holds stage 0 empty
  assign s_tready = adv & ~rst;
  assign push = st_vld[NW] & ~fifo_full;
  assign push_data = {st_quo[NW], st_c1[NW], st_c0[NW]};

  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld[0] <= 1'b0;
    end else if (adv) begin
      st_vld[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_c0[0] <= prod0[PW-1:CHAN_SCALE_BITS];
      st_c1[0] <= prod1[PW-1:CHAN_SCALE_BITS];
      st_quo[0] <= NW'(prod1[PW-1:CHAN_SCALE_BITS]) << (RATIO_SCALE_BITS + 1);
      st_rem[0] <= '0;
    end
  end

  for (genvar k = 1; k <= NW; k++) begin : g_div
    logic [alc_pkg::CH_W:0] rem_sh;
    logic [alc_pkg::CH_W:0] rem_sub;
    logic                   fits;

    assign rem_sh = {st_rem[k-1], st_quo[k-1][NW-1]};
    assign rem_sub = rem_sh - {1'b0, st_c0[k-1]};
    assign fits = rem_sh >= {1'b0, st_c0[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        st_vld[k] <= 1'b0;
      end else if (adv) begin
        st_vld[k] <= st_vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_c0[k] <= st_c0[k-1];
        st_c1[k] <= st_c1[k-1];
        st_rem[k] <= fits ? rem_sub[alc_pkg::CH_W-1:0] : rem_sh[alc_pkg::CH_W-1:0];
        st_quo[k] <= {st_quo[k-1][NW-2:0], fits};
      end
    end
  end

endmodule

// ----- src/alc_fifo.sv -----
module alc_fifo #(
  parameter int WIDTH = 60
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [WIDTH-1:0]    push_data,
  input  logic                pop,
  output logic [WIDTH-1:0]    pop_data,
  output alc_pkg::fifo_stat_t stat
);

  logic [WIDTH-1:0]                  mem [0:alc_pkg::FIFO_DEPTH-1];
  logic [alc_pkg::FIFO_PTR_W-1:0]    wptr;
  logic [alc_pkg::FIFO_PTR_W-1:0]    rptr;
  logic [alc_pkg::FIFO_CNT_W-1:0]    count;

  assign stat.full = count == alc_pkg::FIFO_CNT_W'(alc_pkg::FIFO_DEPTH);
  assign stat.empty = count == '0;
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

endmodule

// ----- src/alc_back.sv -----
module alc_back #(
  parameter int RATIO_SCALE_BITS = 9,
  parameter int LUX_SCALE_BITS = 14
) (
  input  logic                         clk,
  input  logic                         rst,
  input  alc_pkg::cfg_t                cfg,
  input  logic [3*alc_pkg::CH_W+RATIO_SCALE_BITS:0] pop_data,
  input  alc_pkg::fifo_stat_t          fifo_stat,
  output logic                         pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [alc_pkg::LUX_W-1:0]    m_tdata
);

  localparam int NW = alc_pkg::CH_W + 1 + RATIO_SCALE_BITS;
  localparam int CMP_W = NW + alc_pkg::TAB_RATIO_BITS;
  localparam int COEF_W = (LUX_SCALE_BITS > alc_pkg::TAB_COEF_BITS) ?
                          (alc_pkg::TAB_W + LUX_SCALE_BITS - alc_pkg::TAB_COEF_BITS) :
                          alc_pkg::TAB_W;
  localparam int PROD_W = alc_pkg::CH_W + COEF_W;
  localparam int EXT_W = alc_pkg::TAB_W + LUX_SCALE_BITS + 1;

  function automatic logic [COEF_W-1:0] coef_scale(input logic [alc_pkg::TAB_W-1:0] c);
    logic [EXT_W-1:0] t;
    t = (EXT_W'(c) << LUX_SCALE_BITS) >> alc_pkg::TAB_COEF_BITS;
    return t[COEF_W-1:0];
  endfunction

  logic                     adv;
  logic [alc_pkg::CH_W-1:0] in_c0;
  logic [alc_pkg::CH_W-1:0] in_c1;
  logic [NW-1:0]            in_quo;
  logic [NW:0]              quo_inc;
  logic [NW-1:0]            ratio;
  logic [CMP_W-1:0]         ratio_cmp;
  logic [alc_pkg::SEG_W-1:0] seg_sel;

  logic                      b1_vld;
  logic [alc_pkg::CH_W-1:0]  b1_c0;
  logic [alc_pkg::CH_W-1:0]  b1_c1;
  logic [alc_pkg::SEG_W-1:0] b1_seg;

  logic [COEF_W-1:0] coef_b;
  logic [COEF_W-1:0] coef_m;

  logic              b2_vld;
  logic [PROD_W-1:0] b2_pos;
  logic [PROD_W-1:0] b2_neg;

  logic              b3_vld;
  logic [PROD_W-1:0] b3_diff;

  logic [PROD_W:0] lux_sum;
  logic [PROD_W:0] lux_sh;

  assign adv = ~m_tvalid | m_tready;
  assign pop = adv & ~fifo_stat.empty;

  assign in_c0 = pop_data[alc_pkg::CH_W-1:0];
  assign in_c1 = pop_data[2*alc_pkg::CH_W-1:alc_pkg::CH_W];
  assign in_quo = pop_data[2*alc_pkg::CH_W+NW-1:2*alc_pkg::CH_W];

  // round the ratio, a zero broadband count picks the first segment
  assign quo_inc = {1'b0, in_quo} + 1'b1;
  assign ratio = (in_c0 == '0) ? '0 : quo_inc[NW:1];
  assign ratio_cmp = CMP_W'(ratio) << alc_pkg::TAB_RATIO_BITS;

  always_comb begin
    seg_sel = alc_pkg::SEG_W'(alc_pkg::SEGMENTS - 1);
    for (int i = alc_pkg::SEGMENTS - 2; i >= 0; i--) begin
      if (ratio_cmp <= (CMP_W'(alc_pkg::SEG_BRK[cfg.package_kind][i]) << RATIO_SCALE_BITS)) begin
        seg_sel = alc_pkg::SEG_W'(i);
      end
    end
  end

  assign coef_b = coef_scale(alc_pkg::SEG_OFF[cfg.package_kind][b1_seg]);
  assign coef_m = coef_scale(alc_pkg::SEG_SLOPE[cfg.package_kind][b1_seg]);

  assign lux_sum = (PROD_W+1)'(b3_diff) + ((PROD_W+1)'(1) << (LUX_SCALE_BITS - 1));
  assign lux_sh = lux_sum >> LUX_SCALE_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_vld <= 1'b0;
      b2_vld <= 1'b0;
      b3_vld <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      b1_vld <= pop;
      b2_vld <= b1_vld;
      b3_vld <= b2_vld;
      m_tvalid <= b3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_c0 <= in_c0;
      b1_c1 <= in_c1;
      b1_seg <= seg_sel;
      b2_pos <= PROD_W'(b1_c0) * PROD_W'(coef_b);
      b2_neg <= PROD_W'(b1_c1) * PROD_W'(coef_m);
      b3_diff <= (b2_pos > b2_neg) ? (b2_pos - b2_neg) : '0;
      if (lux_sh > (PROD_W+1)'(16'hffff)) begin
        m_tdata <= '1;
      end else begin
        m_tdata <= lux_sh[alc_pkg::LUX_W-1:0];
      end
    end
  end

endmodule

// ----- src/ambient_light_lux_calc_top.sv -----
// Two-channel ambient light lux estimator. Each transaction on the s_ side carries one pair of
// raw sensor counts and yields exactly one rounded lux value on the m_ side, in order. The
// counts are scaled for gain and integration time, their infrared/broadband ratio picks one
// of eight table segments for the selected package, and lux = broadband*B - infrared*M,
// clamped at zero, rounded and saturated at 65535. One transaction is taken every cycle while
// the m_ side keeps up; a full queue can stall the s_ side. The scaling multiply is followed by
// the restoring divider, which resolves one quotient bit per pipeline stage, then a four-entry
// queue and four back-end stages. Registers on the APB port: 0x0 gain_high, 0x4
// integration_time_sel, 0x8 package_kind; change them only while no transaction is in flight.
module ambient_light_lux_calc_top #(
  parameter int CHAN_SCALE_BITS = 10,
  parameter int RATIO_SCALE_BITS = 9,
  parameter int LUX_SCALE_BITS = 14
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [alc_pkg::ADDR_W-1:0] paddr,
  input  logic [alc_pkg::DATA_W-1:0] pwdata,
  output logic [alc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [31:0]                s_tdata,  // broadband_count[15:0], infrared_count[31:16]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [15:0]                m_tdata   // lux_value[15:0]
);

  localparam int ENT_W = 3 * alc_pkg::CH_W + 1 + RATIO_SCALE_BITS;

  alc_pkg::cfg_t       cfg;
  alc_pkg::fifo_stat_t fifo_stat;
  logic                fifo_push;
  logic                fifo_pop;
  logic [ENT_W-1:0]    push_data;
  logic [ENT_W-1:0]    pop_data;

  alc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  alc_front #(
    .CHAN_SCALE_BITS  (CHAN_SCALE_BITS),
    .RATIO_SCALE_BITS (RATIO_SCALE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .fifo_full (fifo_stat.full),
    .push      (fifo_push),
    .push_data (push_data)
  );

  alc_fifo #(
    .WIDTH (ENT_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fifo_push),
    .push_data (push_data),
    .pop       (fifo_pop),
    .pop_data  (pop_data),
    .stat      (fifo_stat)
  );

  alc_back #(
    .RATIO_SCALE_BITS (RATIO_SCALE_BITS),
    .LUX_SCALE_BITS   (LUX_SCALE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_data  (pop_data),
    .fifo_stat (fifo_stat),
    .pop       (fifo_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    fifo_push |-> !fifo_stat.full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    fifo_pop |-> !fifo_stat.empty)
    else $error("queue read while empty");

  a_ready_with_room: assert property (@(posedge clk) disable iff (rst)
    !fifo_stat.full |-> s_tready)
    else $error("front stalled with room in the queue");

  a_pkg_write: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr[alc_pkg::ADDR_W-1:2] == alc_pkg::REG_PKG)
    |=> cfg.package_kind == $past(pwdata[0]))
    else $error("package select not updated by write");
`endif

endmodule

// ----- test/tb_ambient_light_lux_calc_top.sv -----
module tb_ambient_light_lux_calc_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHAN_BITS = 10;
  localparam int RATIO_BITS = 9;
  localparam int LUX_BITS = 14;
  localparam int LATENCY = RATIO_BITS + 31;
  localparam int STUCK_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEMS_PER_SETTING = 52;

  class lux_scoreboard;
    logic        gain_high = 1'b0;
    logic [1:0]  time_sel = alc_pkg::TIME_402MS;
    logic        package_kind = 1'b0;
    logic [15:0] lux_q[$];
    int unsigned mismatches = 0;
    int unsigned results = 0;
    int unsigned inputs = 0;

    function void write_reg(logic [1:0] idx, logic [alc_pkg::DATA_W-1:0] val);
      case (idx)
        alc_pkg::REG_GAIN: gain_high = val[0];
        alc_pkg::REG_TIME: time_sel = val[1:0];
        alc_pkg::REG_PKG: package_kind = val[0];
        default: ;
      endcase
    endfunction

    function logic [15:0] predict_lux(logic [15:0] bb, logic [15:0] ir);
      bit [63:0] scale;
      bit [63:0] c0;
      bit [63:0] c1;
      bit [63:0] ratio;
      bit [63:0] b;
      bit [63:0] m;
      bit [63:0] pos;
      bit [63:0] neg;
      bit [63:0] lux;
      int seg;
      case (time_sel)
        alc_pkg::TIME_13MS: scale = ((64'd322 << CHAN_BITS) * 2 + 64'd11) / 64'd22;
        alc_pkg::TIME_101MS: scale = ((64'd322 << CHAN_BITS) * 2 + 64'd81) / 64'd162;
        default: scale = 64'd1 << CHAN_BITS;
      endcase
      if (!gain_high) scale = scale << alc_pkg::GAIN_SHIFT;
      c0 = (64'(bb) * scale) >> CHAN_BITS;
      c1 = (64'(ir) * scale) >> CHAN_BITS;
      ratio = 64'd0;
      if (c0 != 64'd0) ratio = (c1 << (RATIO_BITS + 1)) / c0;
      ratio = (ratio + 64'd1) >> 1;
      // last segment applies above the seventh breakpoint
      seg = alc_pkg::SEGMENTS - 1;
      for (int i = alc_pkg::SEGMENTS - 2; i >= 0; i--) begin
        if ((ratio << alc_pkg::TAB_RATIO_BITS) <=
            (64'(alc_pkg::SEG_BRK[package_kind][i]) << RATIO_BITS))
          seg = i;
      end
      b = (64'(alc_pkg::SEG_OFF[package_kind][seg]) << LUX_BITS) >> alc_pkg::TAB_COEF_BITS;
      m = (64'(alc_pkg::SEG_SLOPE[package_kind][seg]) << LUX_BITS) >> alc_pkg::TAB_COEF_BITS;
      pos = c0 * b;
      neg = c1 * m;
      lux = (pos > neg) ? pos - neg : 64'd0;
      lux = (lux + (64'd1 << (LUX_BITS - 1))) >> LUX_BITS;
      if (lux > 64'hffff) lux = 64'hffff;
      return lux[15:0];
    endfunction

    function void note_counts(logic [15:0] bb, logic [15:0] ir);
      lux_q.push_back(predict_lux(bb, ir));
      inputs++;
    endfunction

    function void check_lux(logic [15:0] lux);
      logic [15:0] exp_lux;
      results++;
      if (lux_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected lux result %0d with nothing pending", lux);
        return;
      end
      exp_lux = lux_q.pop_front();
      if (lux !== exp_lux) begin
        mismatches++;
        if (mismatches <= 10)
          $display("lux mismatch at result %0d: expected %0d, got %0d", results, exp_lux, lux);
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [alc_pkg::ADDR_W-1:0]   paddr = '0;
  logic [alc_pkg::DATA_W-1:0]   pwdata = '0;
  logic [alc_pkg::DATA_W-1:0]   prdata;
  logic                         pready;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [31:0]                  s_tdata = '0;  // broadband_count[15:0], infrared_count[31:16]
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [15:0]                  m_tdata;   // lux_value[15:0]

  lux_scoreboard lux_sb = new();
  bit            no_idle = 1'b0;
  int unsigned   hold_requests = 0;
  int unsigned   holds_served = 0;
  int unsigned   hold_left = 0;
  int unsigned   stuck_cycles = 0;
  int unsigned   settings_run = 0;

  ambient_light_lux_calc_top #(
    .CHAN_SCALE_BITS(CHAN_BITS),
    .RATIO_SCALE_BITS(RATIO_BITS),
    .LUX_SCALE_BITS(LUX_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random backpressure plus a single long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= no_idle || ($urandom_range(99) >= 18);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) lux_sb.check_lux(m_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STUCK_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [alc_pkg::DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= alc_pkg::ADDR_W'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    lux_sb.write_reg(idx, val);
  endtask

  task automatic send_counts(input logic [15:0] bb, input logic [15:0] ir);
    while (!no_idle && $urandom_range(99) < 18) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {ir, bb};
    do @(posedge clk); while (!s_tready);
    lux_sb.note_counts(bb, ir);
  endtask

  // mostly ratio-targeted pairs so every segment and boundary gets hit
  task automatic pick_counts(output logic [15:0] bb, output logic [15:0] ir);
    int unsigned kind;
    int unsigned r;
    logic [31:0] t;
    kind = $urandom_range(9);
    if (kind == 0) begin
      bb = 16'($urandom);
      ir = 16'($urandom);
    end else if (kind == 1) begin
      bb = $urandom_range(1) ? 16'hffff : 16'($urandom_range(2));
      ir = $urandom_range(1) ? 16'hffff : 16'($urandom_range(2));
    end else begin
      case ($urandom_range(2))
        0: bb = 16'($urandom_range(255));
        1: bb = 16'($urandom_range(4095));
        default: bb = 16'($urandom);
      endcase
      if ($urandom_range(2) == 0)
        r = int'(alc_pkg::SEG_BRK[$urandom_range(1)][$urandom_range(6)]) +
            $urandom_range(2) - 1;
      else
        r = $urandom_range(800);
      t = (32'(bb) * r) >> 9;
      ir = (t > 32'hffff) ? 16'hffff : t[15:0];
    end
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (lux_sb.lux_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [15:0] bb;
    logic [15:0] ir;
    logic [3:0]  combo;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at reset settings: extremes and each breakpoint edge
    send_counts(16'h0000, 16'h0000);
    send_counts(16'h0000, 16'hffff);
    send_counts(16'hffff, 16'h0000);
    send_counts(16'hffff, 16'hffff);
    send_counts(16'h0001, 16'h0001);
    for (int i = 0; i < alc_pkg::SEGMENTS - 1; i++) begin
      send_counts(16'd512, 16'(alc_pkg::SEG_BRK[0][i]));
      send_counts(16'd512, 16'(alc_pkg::SEG_BRK[0][i]) + 16'd1);
    end
    wait_drain();
    settings_run++;

    for (int p = 0; p < 16; p++) begin
      combo = 4'(p);
      write_reg(alc_pkg::REG_GAIN, alc_pkg::DATA_W'(combo[0]));
      write_reg(alc_pkg::REG_TIME, alc_pkg::DATA_W'(combo[2:1]));
      write_reg(alc_pkg::REG_PKG, alc_pkg::DATA_W'(combo[3]));
      no_idle = (p == 6);
      if (p == 3) hold_requests++;
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        pick_counts(bb, ir);
        send_counts(bb, ir);
      end
      wait_drain();
      settings_run++;
    end
    no_idle = 1'b0;

    repeat (LATENCY + 20) @(posedge clk);
    $display("covered %0d count pairs and %0d lux results over %0d register settings",
             lux_sb.inputs, lux_sb.results, settings_run);
    $display("all gain, integration time and package combinations, with one long output stall");
    if (lux_sb.mismatches == 0 && lux_sb.lux_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", lux_sb.mismatches, lux_sb.lux_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
